// ===== sv/ffha_pkg.sv =====
// Package with the request/result words, status codes and controller states of the allocator.
package ffha_pkg;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_NOT_BLK  = 2'd2;

    localparam logic CFG_HEAP_SIZE = 1'b0;
    localparam logic CFG_MIN_CHUNK = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [14:0] request_size;
        logic [15:0] owner_id;
        logic [14:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [14:0] result_offset;
        logic [1:0]  status;
    } t_rsp;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_AWALK,
        S_ASPLIT,
        S_FWALK,
        S_FMRG,
        S_FPUSH
    } t_state;

endpackage

// ===== sv/first_fit_heap_allocator.sv =====
// First-fit heap allocator with neighbor coalescing, built around a block table memory.
//
//  channel   | ports                           | handshake
//  ----------+---------------------------------+-------------------------------------
//  request   | start, busy, i_req              | word taken when start & !busy
//  result    | o_valid, o_rsp                  | o_valid high one cycle, no stall
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data | written when i_cfg_we is high
//
// An allocate walks the address-ordered chain block by block, and then writes the
// split-off remainder in the S_ASPLIT state when the block is split. A free walks up
// to the target, then merges and returns released header slots, the second in S_FPUSH
// when both neighbors merge. The walk is bound by the single read port of the block
// table: one entry per cycle. Reset and every configuration write rebuild the heap as
// one free block. Results cannot be stalled; busy stays low only in the idle state.
module first_fit_heap_allocator #(
    parameter int HEADER_BYTES = 8,
    parameter int MAX_BLOCKS   = 256,
    parameter int HEAP_BYTES   = 32768
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  ffha_pkg::t_req  i_req,
    output logic            o_valid,
    output ffha_pkg::t_rsp  o_rsp,
    input  logic            i_cfg_we,
    input  logic            i_cfg_idx,
    input  logic [15:0]     i_cfg_data
);

    localparam int SLOT_W  = $clog2(MAX_BLOCKS);
    localparam int LINK_W  = SLOT_W + 1;
    localparam int HEAP_LIM = (HEAP_BYTES < 32768) ? HEAP_BYTES : 32768;
    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(MAX_BLOCKS);
    localparam logic [14:0] HDR = 15'(HEADER_BYTES);

    typedef struct packed {
        logic [14:0]       start;
        logic [14:0]       bytes;
        logic [LINK_W-1:0] link;
        logic              used;
        logic [15:0]       owner;
    } t_entry;

    // Block table and spare slot stack.
    t_entry            blk_mem [MAX_BLOCKS];
    logic [SLOT_W-1:0] spr_mem [MAX_BLOCKS];

    ffha_pkg::t_state  r_state, n_state;
    ffha_pkg::t_req    r_req, n_req;
    t_entry            r_brd;
    logic [SLOT_W-1:0] r_srd;
    t_entry            r_pe, n_pe, r_se, n_se, r_sp, n_sp;
    logic [SLOT_W-1:0] r_cur, n_cur, r_sps, n_sps, r_push2, n_push2;
    logic [LINK_W-1:0] r_prev, n_prev;
    logic [LINK_W-1:0] r_count, n_count, r_low, n_low;
    logic [15:0]       r_heap, n_heap;
    logic [7:0]        r_minc, n_minc;
    logic              r_valid, n_valid;
    ffha_pkg::t_rsp    r_rsp, n_rsp;

    logic              b_we, b_re, s_we, s_re;
    logic [SLOT_W-1:0] b_wa, b_ra, s_wa, s_ra;
    t_entry            b_wd;
    logic [SLOT_W-1:0] s_wd;

    // Combinational helpers.
    logic [15:0]       total;
    logic [14:0]       bytes0;
    logic [LINK_W-1:0] top_idx;
    logic [SLOT_W-1:0] top_slot;
    logic [14:0]       rest;
    logic [15:0]       split_lim;
    logic [14:0]       target;
    logic              pmerge, nfree;
    t_entry            base;
    logic [SLOT_W-1:0] base_slot;
    logic [14:0]       msum;

    always_comb begin
        total  = (r_heap > 16'(HEAP_LIM)) ? 16'(HEAP_LIM) : r_heap;
        bytes0 = (total >= 16'(HEADER_BYTES)) ? 15'(total - 16'(HEADER_BYTES)) : 15'd0;
        top_idx = r_count - LINK_W'(1);
        // Entries below the low-water mark were never rewritten since the rebuild.
        top_slot = (top_idx < r_low) ? (SLOT_W'(MAX_BLOCKS - 1) - top_idx[SLOT_W-1:0])
                                     : r_srd;
        rest      = r_brd.bytes - r_req.request_size;
        split_lim = 16'(HEADER_BYTES) + {8'd0, r_minc};
        target    = r_req.free_offset - HDR;
        pmerge    = (r_prev != END_MARK) && !r_pe.used;
        nfree     = (r_se.link != END_MARK) && !r_brd.used;
        base      = pmerge ? r_pe : r_se;
        base_slot = pmerge ? r_prev[SLOT_W-1:0] : r_cur;
        msum      = base.bytes;
        if (pmerge) begin
            msum = 15'(msum + HDR + r_se.bytes);
        end
        if (nfree) begin
            msum = 15'(msum + HDR + r_brd.bytes);
        end
    end

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_pe    = r_pe;
        n_se    = r_se;
        n_sp    = r_sp;
        n_cur   = r_cur;
        n_sps   = r_sps;
        n_push2 = r_push2;
        n_prev  = r_prev;
        n_count = r_count;
        n_low   = r_low;
        n_heap  = r_heap;
        n_minc  = r_minc;
        n_valid = 1'b0;
        n_rsp   = r_rsp;
        b_we = 1'b0; b_wa = '0; b_wd = '0;
        b_re = 1'b0; b_ra = '0;
        s_we = 1'b0; s_wa = '0; s_wd = '0;
        s_re = 1'b0; s_ra = top_idx[SLOT_W-1:0];

        case (r_state)
            ffha_pkg::S_INIT: begin
                b_we = 1'b1;
                b_wa = '0;
                b_wd = '{start: 15'd0, bytes: bytes0, link: END_MARK, used: 1'b0, owner: 16'd0};
                n_count = LINK_W'(MAX_BLOCKS - 1);
                n_low   = LINK_W'(MAX_BLOCKS - 1);
                n_state = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_IDLE: begin
                if (start) begin
                    n_req  = i_req;
                    n_cur  = '0;
                    n_prev = END_MARK;
                    b_re   = 1'b1;
                    b_ra   = '0;
                    s_re   = 1'b1;
                    if (i_req.kind == ffha_pkg::KIND_ALLOC) begin
                        n_state = ffha_pkg::S_AWALK;
                    end else if (i_req.free_offset < HDR) begin
                        n_valid = 1'b1;
                        n_rsp   = '{result_offset: 15'd0, status: ffha_pkg::ST_NOT_BLK};
                    end else begin
                        n_state = ffha_pkg::S_FWALK;
                    end
                end
            end
            ffha_pkg::S_AWALK: begin
                if (!r_brd.used && r_brd.bytes >= r_req.request_size) begin
                    n_valid = 1'b1;
                    n_rsp   = '{result_offset: 15'(r_brd.start + HDR), status: ffha_pkg::ST_OK};
                    b_we = 1'b1;
                    b_wa = r_cur;
                    b_wd = r_brd;
                    b_wd.used  = 1'b1;
                    b_wd.owner = r_req.owner_id;
                    n_state = ffha_pkg::S_IDLE;
                    if ({1'b0, rest} > split_lim && r_count != '0) begin
                        b_wd.bytes = r_req.request_size;
                        b_wd.link  = {1'b0, top_slot};
                        n_sps = top_slot;
                        n_sp  = '{start: 15'(r_brd.start + HDR + r_req.request_size),
                                  bytes: 15'(rest - HDR), link: r_brd.link,
                                  used: 1'b0, owner: r_brd.owner};
                        n_count = top_idx;
                        n_low   = (top_idx < r_low) ? top_idx : r_low;
                        n_state = ffha_pkg::S_ASPLIT;
                    end
                end else if (r_brd.link == END_MARK) begin
                    n_valid = 1'b1;
                    n_rsp   = '{result_offset: 15'd0, status: ffha_pkg::ST_NO_SPACE};
                    n_state = ffha_pkg::S_IDLE;
                end else begin
                    b_re  = 1'b1;
                    b_ra  = r_brd.link[SLOT_W-1:0];
                    n_cur = r_brd.link[SLOT_W-1:0];
                end
            end
            ffha_pkg::S_ASPLIT: begin
                b_we = 1'b1;
                b_wa = r_sps;
                b_wd = r_sp;
                n_state = ffha_pkg::S_IDLE;
            end
            ffha_pkg::S_FWALK: begin
                if (r_brd.start == target) begin
                    n_se = r_brd;
                    n_se.used  = 1'b0;
                    n_se.owner = 16'd0;
                    // Fetch the successor so it can be merged next cycle.
                    b_re = 1'b1;
                    b_ra = r_brd.link[SLOT_W-1:0];
                    n_state = ffha_pkg::S_FMRG;
                end else if (r_brd.link == END_MARK) begin
                    n_valid = 1'b1;
                    n_rsp   = '{result_offset: 15'd0, status: ffha_pkg::ST_NOT_BLK};
                    n_state = ffha_pkg::S_IDLE;
                end else begin
                    n_prev = {1'b0, r_cur};
                    n_pe   = r_brd;
                    b_re   = 1'b1;
                    b_ra   = r_brd.link[SLOT_W-1:0];
                    n_cur  = r_brd.link[SLOT_W-1:0];
                end
            end
            ffha_pkg::S_FMRG: begin
                b_we = 1'b1;
                b_wa = base_slot;
                b_wd = base;
                b_wd.bytes = msum;
                if (nfree) begin
                    b_wd.link = r_brd.link;
                end else if (pmerge) begin
                    b_wd.link = r_se.link;
                end
                n_valid = 1'b1;
                n_rsp   = '{result_offset: 15'(base.start + HDR), status: ffha_pkg::ST_OK};
                n_state = ffha_pkg::S_IDLE;
                if (pmerge || nfree) begin
                    if (r_count < LINK_W'(MAX_BLOCKS)) begin
                        s_we = 1'b1;
                        s_wa = r_count[SLOT_W-1:0];
                        s_wd = pmerge ? r_cur : r_se.link[SLOT_W-1:0];
                        n_count = r_count + LINK_W'(1);
                    end
                    if (pmerge && nfree) begin
                        n_push2 = r_se.link[SLOT_W-1:0];
                        n_state = ffha_pkg::S_FPUSH;
                    end
                end
            end
            ffha_pkg::S_FPUSH: begin
                if (r_count < LINK_W'(MAX_BLOCKS)) begin
                    s_we = 1'b1;
                    s_wa = r_count[SLOT_W-1:0];
                    s_wd = r_push2;
                    n_count = r_count + LINK_W'(1);
                end
                n_state = ffha_pkg::S_IDLE;
            end
            default: begin
                n_state = ffha_pkg::S_INIT;
            end
        endcase

        if (i_cfg_we) begin
            if (i_cfg_idx == ffha_pkg::CFG_HEAP_SIZE) begin
                n_heap = i_cfg_data;
            end else begin
                n_minc = i_cfg_data[7:0];
            end
            n_state = ffha_pkg::S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            blk_mem[b_wa] <= b_wd;
        end
        if (b_re) begin
            r_brd <= blk_mem[b_ra];
        end
        if (s_we) begin
            spr_mem[s_wa] <= s_wd;
        end
        if (s_re) begin
            r_srd <= spr_mem[s_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffha_pkg::S_INIT;
            r_heap  <= 16'd32768;
            r_minc  <= 8'd8;
            r_valid <= 1'b0;
            r_count <= LINK_W'(MAX_BLOCKS - 1);
            r_low   <= LINK_W'(MAX_BLOCKS - 1);
        end else begin
            r_state <= n_state;
            r_heap  <= n_heap;
            r_minc  <= n_minc;
            r_valid <= n_valid;
            r_count <= n_count;
            r_low   <= n_low;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_pe    <= n_pe;
        r_se    <= n_se;
        r_sp    <= n_sp;
        r_cur   <= n_cur;
        r_sps   <= n_sps;
        r_push2 <= n_push2;
        r_prev  <= n_prev;
        r_rsp   <= n_rsp;
    end

    assign busy    = (r_state != ffha_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== tb/tb_first_fit_heap_allocator.sv =====
// Testbench for the first-fit heap allocator: random and directed requests checked against a predictor.
module tb_first_fit_heap_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDR       = 8;
    localparam int SLOTS     = 256;
    localparam int HEAP_MAX  = 32768;
    localparam int END_SLOT  = SLOTS;
    localparam int CYCLE_CAP = 1500000;
    localparam int SETTLE    = 300;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    ffha_pkg::t_req  i_req;
    logic            o_valid;
    ffha_pkg::t_rsp  o_rsp;
    logic            i_cfg_we;
    logic            i_cfg_idx;
    logic [15:0]     i_cfg_data;

    first_fit_heap_allocator i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Shadow copy of the allocator's block table and registers.
    logic [15:0] heap_reg;
    logic [7:0]  chunk_reg;
    logic [14:0] blk_start [SLOTS];
    logic [14:0] blk_bytes [SLOTS];
    logic [8:0]  blk_link  [SLOTS];
    logic        blk_used  [SLOTS];
    logic [15:0] blk_owner [SLOTS];
    logic [8:0]  spare_stack [SLOTS];
    int          spare_depth;

    ffha_pkg::t_req req_fifo[$];
    ffha_pkg::t_rsp rsp_fifo[$];
    int   live_offs[$];
    int   fails;
    int   cycles;
    bit   taken;
    bit   quiet;
    bit   hold_off;

    function automatic void rebuild_heap();
        int total;
        total = heap_reg;
        if (total > HEAP_MAX) total = HEAP_MAX;
        for (int i = 0; i < SLOTS; i++) begin
            blk_start[i] = '0;
            blk_bytes[i] = '0;
            blk_used[i]  = 1'b0;
            blk_owner[i] = '0;
            blk_link[i]  = 9'(END_SLOT);
        end
        blk_bytes[0] = (total >= HDR) ? 15'(total - HDR) : 15'd0;
        spare_depth = 0;
        for (int i = SLOTS - 1; i >= 1; i--) begin
            spare_stack[spare_depth] = 9'(i);
            spare_depth++;
        end
        live_offs.delete();
    endfunction

    function automatic void merge_next(int s);
        int n;
        n = blk_link[s];
        if (n >= SLOTS) return;
        blk_bytes[s] = 15'(int'(blk_bytes[s]) + HDR + int'(blk_bytes[n]));
        blk_link[s]  = blk_link[n];
        blk_used[n]  = 1'b0;
        blk_owner[n] = '0;
        blk_link[n]  = 9'(END_SLOT);
        if (spare_depth < SLOTS) begin
            spare_stack[spare_depth] = 9'(n);
            spare_depth++;
        end
    endfunction

    function automatic ffha_pkg::t_rsp predict_alloc(int size, logic [15:0] owner);
        ffha_pkg::t_rsp r;
        int   s;
        int   rest;
        int   n;
        s = 0;
        r.result_offset = '0;
        r.status = ffha_pkg::ST_NO_SPACE;
        for (int steps = 0; steps < SLOTS && s < SLOTS; steps++) begin
            if (!blk_used[s] && int'(blk_bytes[s]) >= size) begin
                rest = int'(blk_bytes[s]) - size;
                if (rest > HDR + int'(chunk_reg) && spare_depth > 0) begin
                    spare_depth--;
                    n = spare_stack[spare_depth];
                    blk_start[n] = 15'(int'(blk_start[s]) + HDR + size);
                    blk_bytes[n] = 15'(rest - HDR);
                    blk_link[n]  = blk_link[s];
                    blk_used[n]  = 1'b0;
                    blk_owner[n] = blk_owner[s];
                    blk_bytes[s] = 15'(size);
                    blk_link[s]  = 9'(n);
                end
                blk_used[s]  = 1'b1;
                blk_owner[s] = owner;
                r.result_offset = 15'(int'(blk_start[s]) + HDR);
                r.status = ffha_pkg::ST_OK;
                return r;
            end
            s = blk_link[s];
        end
        return r;
    endfunction

    function automatic ffha_pkg::t_rsp predict_free(int offset);
        ffha_pkg::t_rsp r;
        int   s;
        int   prev;
        int   target;
        int   n;
        r.result_offset = '0;
        r.status = ffha_pkg::ST_NOT_BLK;
        if (offset < HDR) return r;
        target = offset - HDR;
        s = 0;
        prev = END_SLOT;
        for (int steps = 0; steps < SLOTS && s < SLOTS; steps++) begin
            if (int'(blk_start[s]) == target) break;
            prev = s;
            s = blk_link[s];
        end
        if (s >= SLOTS) return r;
        if (int'(blk_start[s]) != target) return r;
        blk_used[s]  = 1'b0;
        blk_owner[s] = '0;
        if (prev < SLOTS && !blk_used[prev]) begin
            merge_next(prev);
            s = prev;
        end
        n = blk_link[s];
        if (n < SLOTS && !blk_used[n]) merge_next(s);
        r.result_offset = 15'(int'(blk_start[s]) + HDR);
        r.status = ffha_pkg::ST_OK;
        return r;
    endfunction

    // Accepted words are predicted at the edge that takes them.
    always @(posedge i_clk) begin
        ffha_pkg::t_rsp want;
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("tb_first_fit_heap_allocator NOT OK");
            $finish;
        end
        taken = i_rst_n && start && !busy;
        if (!i_rst_n) begin
            heap_reg  = 16'd32768;
            chunk_reg = 8'd8;
            rebuild_heap();
        end else if (i_cfg_we) begin
            if (i_cfg_idx == ffha_pkg::CFG_HEAP_SIZE) heap_reg = i_cfg_data;
            else chunk_reg = i_cfg_data[7:0];
            rebuild_heap();
        end
        if (i_rst_n && o_valid) begin
            if (rsp_fifo.size() == 0) begin
                $error("result word with nothing expected: offset %0d status %0d",
                       o_rsp.result_offset, o_rsp.status);
                fails++;
            end else begin
                want = rsp_fifo.pop_front();
                if (o_rsp.result_offset !== want.result_offset) begin
                    $error("result_offset: expected %0d, got %0d",
                           want.result_offset, o_rsp.result_offset);
                    fails++;
                end
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_rsp.status);
                    fails++;
                end
            end
        end
        if (taken) begin
            if (i_req.kind == ffha_pkg::KIND_ALLOC) begin
                want = predict_alloc(int'(i_req.request_size), i_req.owner_id);
                if (want.status == ffha_pkg::ST_OK) live_offs.push_back(want.result_offset);
            end else begin
                want = predict_free(int'(i_req.free_offset));
                for (int k = 0; k < live_offs.size(); k++)
                    if (live_offs[k] == int'(i_req.free_offset)) begin
                        live_offs.delete(k);
                        break;
                    end
            end
            rsp_fifo.push_back(want);
        end
    end

    // Driver: a word stays on the port until the block takes it.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !taken) begin
            start <= 1'b1;
        end else if (req_fifo.size() > 0 && !hold_off
                     && (quiet || $urandom_range(99) >= 32)) begin
            start <= 1'b1;
            i_req <= req_fifo.pop_front();
        end else begin
            start <= 1'b0;
        end
    end

    task automatic queue_word(ffha_pkg::t_req w);
        req_fifo.push_back(w);
        while (req_fifo.size() >= 2) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (req_fifo.size() > 0 || start || rsp_fifo.size() > 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic ffha_pkg::t_req alloc_word(int size, int owner);
        ffha_pkg::t_req w;
        w = '0;
        w.kind = ffha_pkg::KIND_ALLOC;
        w.request_size = 15'(size);
        w.owner_id = 16'(owner);
        w.free_offset = 15'($urandom);
        return w;
    endfunction

    function automatic ffha_pkg::t_req free_word(int offset);
        ffha_pkg::t_req w;
        w = '0;
        w.kind = ffha_pkg::KIND_FREE;
        w.request_size = 15'($urandom);
        w.owner_id = 16'($urandom);
        w.free_offset = 15'(offset);
        return w;
    endfunction

    // Mostly alloc/free traffic on live blocks, with some junk offsets and huge sizes.
    function automatic ffha_pkg::t_req random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            if ($urandom_range(19) == 0) return alloc_word($urandom_range(32767), $urandom);
            return alloc_word($urandom_range(300), $urandom);
        end
        if (pick < 88 && live_offs.size() > 0)
            return free_word(live_offs[$urandom_range(live_offs.size() - 1)]);
        if (pick < 94) return free_word($urandom_range(32767));
        return free_word($urandom_range(HDR - 1));
    endfunction

    task automatic run_random(int count);
        repeat (count) queue_word(random_word());
    endtask

    initial begin
        int off_a;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = ffha_pkg::CFG_HEAP_SIZE;
        i_cfg_data = '0;
        fails      = 0;
        cycles     = 0;
        quiet      = 1'b0;
        hold_off   = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed corner cases on the reset heap.
        queue_word(alloc_word(0, 0));
        queue_word(alloc_word(32767, 16'hFFFF));
        queue_word(alloc_word(100, 16'hFFFF));
        queue_word(alloc_word(8, 16'h1234));
        queue_word(alloc_word(20, 16'h0001));
        queue_word(free_word(0));
        queue_word(free_word(HDR - 1));
        queue_word(free_word(9));
        queue_word(free_word(32767));
        wait_drained();
        off_a = live_offs.size() > 1 ? live_offs[1] : HDR;
        queue_word(free_word(off_a));
        queue_word(free_word(off_a));
        queue_word(free_word(HDR));
        queue_word(alloc_word(32700, 16'h5555));
        queue_word(alloc_word(32760, 16'hAAAA));
        queue_word(free_word(HDR));
        wait_drained();

        // The sender holds until all results are back, word by word.
        hold_off = 1'b0;
        repeat (20) begin
            queue_word(random_word());
            wait_drained();
        end

        quiet = 1'b1;
        run_random(150);
        quiet = 1'b0;
        run_random(200);
        wait_drained();

        write_reg(ffha_pkg::CFG_HEAP_SIZE, 16'hFFFF);
        write_reg(ffha_pkg::CFG_MIN_CHUNK, 16'd0);
        run_random(200);
        wait_drained();

        write_reg(ffha_pkg::CFG_HEAP_SIZE, 16'd64);
        write_reg(ffha_pkg::CFG_MIN_CHUNK, 16'd255);
        run_random(60);
        wait_drained();

        // Heap smaller than one header leaves a block with no data bytes.
        write_reg(ffha_pkg::CFG_HEAP_SIZE, 16'd5);
        queue_word(alloc_word(0, 7));
        queue_word(alloc_word(1, 7));
        queue_word(free_word(HDR));
        wait_drained();

        write_reg(ffha_pkg::CFG_HEAP_SIZE, 16'd4000);
        write_reg(ffha_pkg::CFG_MIN_CHUNK, 16'd24);
        run_random(150);
        wait_drained();

        write_reg(ffha_pkg::CFG_HEAP_SIZE, 16'd32768);
        write_reg(ffha_pkg::CFG_MIN_CHUNK, 16'd8);
        run_random(120);
        wait_drained();

        repeat (SETTLE) @(negedge i_clk);
        if (fails == 0) begin
            $display("tb_first_fit_heap_allocator OK");
        end else begin
            $display("tb_first_fit_heap_allocator NOT OK");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/ffha_pkg.sv
sv/first_fit_heap_allocator.sv
tb/tb_first_fit_heap_allocator.sv
